[rtl/tcg_pkg.sv]
`default_nettype none

package tcg_pkg;

	// Store geometry
	localparam int FRAME_WORDS = 4096;
	localparam int FONT_WORDS  = 16384;
	localparam int FRAME_AW    = $clog2(FRAME_WORDS);
	localparam int FONT_AW     = $clog2(FONT_WORDS);
	localparam int CELL_DOTS   = 10;

	// Scan line handling
	localparam int MAX_LINES   = 32;
	localparam int SHIFT_ROWS  = 6;
	localparam logic [13:0] ALT_FONT_BASE = 14'h2000;

	// Request kinds
	localparam logic [1:0] KIND_RENDER = 2'd0;
	localparam logic [1:0] KIND_FRAME  = 2'd1;
	localparam logic [1:0] KIND_FONT   = 2'd2;

	// Configuration register indexes
	localparam logic CFG_LINES_PER_ROW  = 1'b0;
	localparam logic CFG_UNDERLINE_LINE = 1'b1;

	// Frame word attribute bits
	localparam int BIT_ALT    = 8;
	localparam int BIT_UNDER  = 9;
	localparam int BIT_INVERT = 11;
	localparam int BIT_HIDE   = 12;
	localparam int BIT_HILITE = 13;
	localparam int BIT_SUB    = 14;
	localparam int BIT_SUPER  = 15;

	typedef struct packed {
		logic [1:0]  kind;
		logic [17:0] cell_address;
		logic [17:0] cursor_address;
		logic        cursor_enable;
		logic        row_end;
		logic [13:0] write_address;
		logic [15:0] write_data;
	} in_req_t;

	typedef struct packed {
		logic [4:0]           scan_line;
		logic [CELL_DOTS-1:0] dots;
		logic                 bright;
		logic                 last_line;
		logic                 row_end_out;
	} out_req_t;

	typedef enum logic {
		ST_IDLE,
		ST_LINES
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic write_frame;
		logic write_font;
		logic start_render;
		logic issue;
	} tcg_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic render_zero;
		logic line_last;
		logic issue_ok;
	} tcg_stat_t;

endpackage

`default_nettype wire

[rtl/tcg_ctrl.sv]
`default_nettype none

module tcg_ctrl import tcg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] kind,
	input  wire tcg_stat_t  status,
	output logic            in_stall,
	output tcg_cmd_t        cmd
);

	ctrl_state_t state_q, state_d;
	logic        accepted;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// input is open only in idle
	assign accepted = in_valid && (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (accepted) begin
					unique case (kind)
						KIND_RENDER: begin
							cmd.start_render = 1'b1;
							if (!status.render_zero) begin
								state_d = ST_LINES;
							end
						end
						KIND_FRAME: cmd.write_frame = 1'b1;
						KIND_FONT:  cmd.write_font  = 1'b1;
						default: ;
					endcase
				end
			end
			ST_LINES: begin
				// one font read per cycle while the line stage has room
				cmd.issue = status.issue_ok;
				if (status.issue_ok && status.line_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_last_line_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue && status.line_last |=> state_q == ST_IDLE)
		else $error("controller did not return to idle after the last line");

	a_render_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_render && !status.render_zero |=> state_q == ST_LINES)
		else $error("render request did not start line issue");

	a_no_write_in_lines: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LINES |-> !(cmd.write_frame || cmd.write_font || cmd.start_render))
		else $error("store write or render start while lines pending");

endmodule

`default_nettype wire

[rtl/tcg_datapath.sv]
`default_nettype none

module tcg_datapath import tcg_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_req_t  in_data,
	input  wire tcg_cmd_t cmd,
	output tcg_stat_t     status,
	input  wire logic     cfg_valid,
	output logic          cfg_ready,
	input  wire logic     cfg_index,
	input  wire logic [5:0] cfg_data,
	output logic          out_valid,
	input  wire logic     out_stall,
	output out_req_t      out_data
);

	// Stores
	logic [15:0] frame_mem [FRAME_WORDS];
	logic [15:0] font_mem  [FONT_WORDS];

	// Configuration
	logic [5:0] lines_per_row_q;
	logic [4:0] underline_line_q;

	// Per cell state
	logic [15:0] frame_word_q;
	logic [5:0]  lines_q;
	logic [4:0]  line_q;
	logic        cursor_q;
	logic        row_end_q;

	// Line stage (font read data)
	logic                 valid_s1;
	logic [15:0]          font_word_s1;
	logic [4:0]           line_s1;
	logic                 last_s1;
	logic                 force_s1;
	logic                 blank_s1;
	logic                 rev_s1;
	logic                 bold_s1;
	logic                 row_end_s1;

	// Output register
	logic     out_valid_q;
	out_req_t out_q;

	logic [5:0]           lines_sat;
	logic [4:0]           row;
	logic [13:0]          font_full;
	logic [FONT_AW-1:0]   font_addr;
	logic                 advance;
	logic [CELL_DOTS-1:0] dots;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_per_row_q  <= 6'd24;
			underline_line_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LINES_PER_ROW:  lines_per_row_q  <= cfg_data;
				CFG_UNDERLINE_LINE: underline_line_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign lines_sat = (lines_per_row_q > 6'(MAX_LINES)) ? 6'(MAX_LINES) : lines_per_row_q;

	// Frame store: write port and cell fetch
	always_ff @(posedge clk) begin
		if (cmd.write_frame) begin
			frame_mem[in_data.write_address[FRAME_AW-1:0]] <= in_data.write_data;
		end
		if (cmd.start_render) begin
			frame_word_q <= frame_mem[in_data.cell_address[FRAME_AW-1:0]];
		end
	end

	// Cell registers
	always_ff @(posedge clk) begin
		if (cmd.start_render) begin
			lines_q   <= lines_sat;
			cursor_q  <= in_data.cursor_enable &&
				(in_data.cell_address == in_data.cursor_address);
			row_end_q <= in_data.row_end;
		end
	end

	// Line counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
		end else if (cmd.start_render) begin
			line_q <= '0;
		end else if (cmd.issue) begin
			line_q <= line_q + 5'd1;
		end
	end

	// Font row with superscript / subscript offset
	always_comb begin
		row = line_q;
		if (frame_word_q[BIT_SUPER]) begin
			row = line_q + 5'(SHIFT_ROWS);
		end else if (frame_word_q[BIT_SUB]) begin
			row = (line_q >= 5'(SHIFT_ROWS)) ? line_q - 5'(SHIFT_ROWS) : '0;
		end
	end

	assign font_full = (frame_word_q[BIT_ALT] ? ALT_FONT_BASE : 14'd0) |
		{1'b0, frame_word_q[7:0], row};
	assign font_addr = font_full[FONT_AW-1:0];

	assign advance = !out_valid_q || !out_stall;

	assign status.render_zero = (lines_per_row_q == 6'd0);
	assign status.line_last   = (line_q == 5'(lines_q - 6'd1));
	assign status.issue_ok    = !valid_s1 || advance;

	// Font store: write port and line read
	always_ff @(posedge clk) begin
		if (cmd.write_font) begin
			font_mem[in_data.write_address[FONT_AW-1:0]] <= in_data.write_data;
		end
		if (cmd.issue) begin
			font_word_s1 <= font_mem[font_addr];
		end
	end

	// Line stage side info
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			line_s1    <= line_q;
			last_s1    <= status.line_last;
			force_s1   <= cursor_q ||
				(frame_word_q[BIT_UNDER] && (line_q == underline_line_q));
			blank_s1   <= frame_word_q[BIT_HIDE];
			rev_s1     <= frame_word_q[BIT_INVERT];
			bold_s1    <= frame_word_q[BIT_HILITE];
			row_end_s1 <= row_end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.issue) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Dot modifiers: force on, blank, reverse
	always_comb begin
		dots = font_word_s1[CELL_DOTS-1:0];
		if (force_s1) begin
			dots = '1;
		end
		if (blank_s1) begin
			dots = '0;
		end
		if (rev_s1) begin
			dots = ~dots;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q.scan_line   <= line_s1;
			out_q.dots        <= dots;
			out_q.bright      <= bold_s1;
			out_q.last_line   <= last_s1;
			out_q.row_end_out <= row_end_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_issue_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (!valid_s1 || advance))
		else $error("font read issued into a full line stage");

	a_line_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(font_word_s1))
		else $error("line stage lost data while output blocked");

	a_lines_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.start_render) |-> (lines_q <= 6'(MAX_LINES)))
		else $error("line count above maximum");

endmodule

`default_nettype wire

[rtl/text_cell_character_generator_top.sv]
`default_nettype none

// Text cell character generator. A request of kind write frame or write font
// loads one 16-bit word into the 4K-word frame store or the 16K-word font
// store. A render request registers the cell's frame word and then issues one
// font read per cycle while the line stage has room, so a cell of N scan lines
// (N = lines_per_row, saturated at 32; 24 after reset) delivers its N results
// at one per cycle while the output is not stalled, each through the line
// stage and the output register; the single font read port sets that pace.
// The input is stalled while a cell's lines are being issued; the next request
// is taken as soon as the last font read is out, while earlier lines still
// drain through the output register. A render with lines_per_row zero gives no
// results. Store contents are undefined until written. The user must write
// configuration only while the block is idle; the block itself does not
// enforce this.
module text_cell_character_generator_top import tcg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_req_t    in_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_req_t        out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [5:0] cfg_data
);

	tcg_cmd_t  cmd;
	tcg_stat_t status;

	tcg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (in_data.kind),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	tcg_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
